// File: hw/rtl/ordered_array_table_engine_macros.svh
// Assertion macros shared by the ordered array table engine RTL
`ifndef ORDERED_ARRAY_TABLE_ENGINE_MACROS_SVH
`define ORDERED_ARRAY_TABLE_ENGINE_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off during reset
`define OATE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset
`define OATE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/oate_pkg.sv
// Types and constants of the ordered array table engine
package oate_pkg;

  localparam int unsigned DepthDef = 256;

  typedef enum logic [2:0] {
    ACT_PUSH   = 3'd0,
    ACT_POP    = 3'd1,
    ACT_INSERT = 3'd2,
    ACT_DELETE = 3'd3,
    ACT_REMOVE = 3'd4,
    ACT_FIND   = 3'd5,
    ACT_SEARCH = 3'd6,
    ACT_READ   = 3'd7
  } action_e;

  typedef enum logic [2:0] {
    STS_OK    = 3'd0,
    STS_RANGE = 3'd1,
    STS_MISS  = 3'd2,
    STS_FULL  = 3'd3,
    STS_EMPTY = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SETTLE,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    CM_HOLD,
    CM_SHIFT,
    CM_SETTLE
  } cell_mode_e;

  // One slot of the chain: entry plus a hole mark used while compacting
  typedef struct packed {
    logic               hole;
    logic signed [31:0] data;
  } cell_t;

endpackage

// File: hw/rtl/ordered_array_table_engine.sv
// Ordered array table engine: sequencer plus a ring of entry cells
//
// Input channel (in_valid_i / in_stall_o) carries action, index and value;
// output channel (out_valid_o / out_stall_i) returns one result beat per
// input beat. A beat moves when valid is high and stall is low.
// Entries live in a ring of DEPTH cells. Every accepted action rotates the
// ring once (binary search may rotate it again), reading entry k at cell 0
// and writing the new entry k at the top cell. Remove all adds a compaction
// pass in which holes bubble up one cell per cycle. Binary search probes one
// entry per pass and rotates again until the search interval closes.
// Rejected actions skip the rotation and go straight to the result.
// One item is in work at a time; the next input beat is taken as soon as
// the result is in the output register, even while the receiver stalls.
// A stalled result holds; a finished item waits for the output register.
// Reset empties the table (count zero); no clearing pass is needed.
module ordered_array_table_engine #(
  parameter int unsigned DEPTH = oate_pkg::DepthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         action_i,
  input  logic [8:0]         index_i,
  input  logic signed [31:0] value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         status_o,
  output logic signed [31:0] data_o,
  output logic [7:0]         position_o,
  output logic [8:0]         removed_count_o,
  output logic [8:0]         entry_count_o,
  output logic               is_empty_o
);

  `include "ordered_array_table_engine_macros.svh"

  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned KW = $clog2(2 * DEPTH);
  localparam int unsigned MW = (KW > 9) ? KW : 9;

  oate_pkg::cell_t      chain [DEPTH];
  oate_pkg::cell_t      tail;
  oate_pkg::cell_t      bottom;
  oate_pkg::cell_mode_e mode;

  oate_pkg::state_e    state_q, state_d;
  oate_pkg::action_e   op_q, op_d;
  logic [8:0]          idx_q, idx_d;
  logic signed [31:0]  val_q, val_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic [KW-1:0]       k_q, k_d;
  logic signed [31:0]  carry_q, carry_d;
  oate_pkg::status_e   sts_q, sts_d;
  logic signed [31:0]  res_q, res_d;
  logic [IW-1:0]       pos_q, pos_d;
  logic [CW-1:0]       rem_q, rem_d;
  logic [CW-1:0]       lo_q, lo_d, hi_q, hi_d;
  logic                sdone_q, sdone_d;

  logic                ov_q, ov_d;
  logic [2:0]          o_sts_q, o_sts_d;
  logic signed [31:0]  o_data_q, o_data_d;
  logic [7:0]          o_pos_q, o_pos_d;
  logic [8:0]          o_rem_q, o_rem_d, o_cnt_q, o_cnt_d;
  logic                o_emp_q, o_emp_d;

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      oate_cell u_cell (
        .clk_i  (clk_i),
        .mode_i (mode),
        .up_i   ((gi == DEPTH - 1) ? tail : chain[(gi + 1) % DEPTH]),
        .dn_i   ((gi == 0) ? bottom : chain[(gi + DEPTH - 1) % DEPTH]),
        .q_o    (chain[gi])
      );
    end
  endgenerate

  assign bottom = '{hole: 1'b0, data: 32'sd0};

  always_comb begin
    logic [MW-1:0]      k_m, cnt_m, idx_m, mid_m;
    logic [CW-1:0]      mid;
    logic               last;
    logic               hit;
    logic signed [31:0] e0, e1;
    oate_pkg::action_e  act;

    state_d = state_q;
    op_d    = op_q;
    idx_d   = idx_q;
    val_d   = val_q;
    cnt_d   = cnt_q;
    k_d     = k_q;
    carry_d = carry_q;
    sts_d   = sts_q;
    res_d   = res_q;
    pos_d   = pos_q;
    rem_d   = rem_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    sdone_d = sdone_q;
    ov_d     = ov_q;
    o_sts_d  = o_sts_q;
    o_data_d = o_data_q;
    o_pos_d  = o_pos_q;
    o_rem_d  = o_rem_q;
    o_cnt_d  = o_cnt_q;
    o_emp_d  = o_emp_q;
    mode       = oate_pkg::CM_HOLD;
    tail.hole  = 1'b1;
    tail.data  = chain[0].data;
    in_stall_o = 1'b1;

    k_m   = MW'(k_q);
    cnt_m = MW'(cnt_q);
    idx_m = MW'(idx_q);
    mid   = lo_q + ((hi_q - lo_q) >> 1);
    mid_m = MW'(mid);
    last  = (k_q == KW'(DEPTH - 1));
    e0    = chain[0].data;
    e1    = chain[(DEPTH > 1) ? 1 : 0].data;
    act   = oate_pkg::action_e'(action_i);
    hit   = 1'b0;

    if (ov_q && !out_stall_i) begin
      ov_d = 1'b0;
    end

    unique case (state_q)
      oate_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          op_d    = act;
          idx_d   = index_i;
          val_d   = value_i;
          k_d     = '0;
          res_d   = '0;
          pos_d   = '0;
          rem_d   = '0;
          lo_d    = '0;
          hi_d    = cnt_q;
          sdone_d = (cnt_q == '0);
          sts_d   = oate_pkg::STS_OK;
          state_d = oate_pkg::ST_SCAN;
          case (act)
            oate_pkg::ACT_PUSH: begin
              if (cnt_m == MW'(DEPTH)) sts_d = oate_pkg::STS_FULL;
            end
            oate_pkg::ACT_POP: begin
              if (cnt_q == '0) sts_d = oate_pkg::STS_EMPTY;
            end
            oate_pkg::ACT_INSERT: begin
              if (MW'(index_i) > cnt_m) sts_d = oate_pkg::STS_RANGE;
              else if (cnt_m == MW'(DEPTH)) sts_d = oate_pkg::STS_FULL;
            end
            oate_pkg::ACT_DELETE, oate_pkg::ACT_READ: begin
              if (MW'(index_i) >= cnt_m) sts_d = oate_pkg::STS_RANGE;
            end
            oate_pkg::ACT_FIND, oate_pkg::ACT_SEARCH: begin
              sts_d = oate_pkg::STS_MISS;
            end
            default: begin
              sts_d = oate_pkg::STS_OK;
            end
          endcase
          if (sts_d == oate_pkg::STS_RANGE || sts_d == oate_pkg::STS_FULL ||
              sts_d == oate_pkg::STS_EMPTY) begin
            state_d = oate_pkg::ST_DONE;
          end
        end
      end

      oate_pkg::ST_SCAN: begin
        mode      = oate_pkg::CM_SHIFT;
        tail.hole = 1'b0;
        tail.data = e0;
        carry_d   = e0;
        case (op_q)
          oate_pkg::ACT_PUSH: begin
            if (k_m == cnt_m) tail.data = val_q;
          end
          oate_pkg::ACT_POP: begin
            if (k_m + MW'(1) == cnt_m) res_d = e0;
          end
          oate_pkg::ACT_INSERT: begin
            if (k_m == idx_m) tail.data = val_q;
            else if (k_m > idx_m) tail.data = carry_q;
          end
          oate_pkg::ACT_DELETE: begin
            if (k_m >= idx_m) tail.data = e1;
            if (k_m == idx_m) res_d = e0;
          end
          oate_pkg::ACT_REMOVE: begin
            hit       = (k_m < cnt_m) && (e0 == val_q);
            tail.hole = (k_m >= cnt_m) || (e0 == val_q);
            if (hit) rem_d = rem_q + CW'(1);
          end
          oate_pkg::ACT_FIND: begin
            if (sts_q == oate_pkg::STS_MISS && k_m < cnt_m && e0 == val_q) begin
              sts_d = oate_pkg::STS_OK;
              pos_d = k_q[IW-1:0];
            end
          end
          oate_pkg::ACT_SEARCH: begin
            if (!sdone_q && k_m == mid_m) begin
              if (e0 == val_q) begin
                sts_d   = oate_pkg::STS_OK;
                pos_d   = mid[IW-1:0];
                sdone_d = 1'b1;
              end else begin
                if (e0 < val_q) lo_d = mid + CW'(1);
                else hi_d = mid;
                sdone_d = ((e0 < val_q) ? (mid + CW'(1)) : lo_q) >=
                          ((e0 < val_q) ? hi_q : mid);
              end
            end
          end
          default: begin
            if (k_m == idx_m) res_d = e0;
          end
        endcase
        k_d = last ? '0 : k_q + KW'(1);
        if (last) begin
          if (op_q == oate_pkg::ACT_REMOVE) begin
            state_d = oate_pkg::ST_SETTLE;
          end else if (op_q != oate_pkg::ACT_SEARCH || sdone_d) begin
            state_d = oate_pkg::ST_DONE;
            case (op_q)
              oate_pkg::ACT_PUSH, oate_pkg::ACT_INSERT: cnt_d = cnt_q + CW'(1);
              oate_pkg::ACT_POP, oate_pkg::ACT_DELETE:  cnt_d = cnt_q - CW'(1);
              default:                                  cnt_d = cnt_q;
            endcase
          end
        end
      end

      oate_pkg::ST_SETTLE: begin
        mode = oate_pkg::CM_SETTLE;
        k_d  = k_q + KW'(1);
        if (k_q == KW'(2 * DEPTH - 1)) begin
          k_d     = '0;
          cnt_d   = cnt_q - rem_q;
          state_d = oate_pkg::ST_DONE;
        end
      end

      oate_pkg::ST_DONE: begin
        if (!ov_q || !out_stall_i) begin
          ov_d     = 1'b1;
          o_sts_d  = sts_q;
          o_data_d = res_q;
          o_pos_d  = (sts_q == oate_pkg::STS_OK) ? 8'(pos_q) : 8'd0;
          o_rem_d  = 9'(rem_q);
          o_cnt_d  = 9'(cnt_q);
          o_emp_d  = (cnt_q == '0);
          state_d  = oate_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = oate_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= oate_pkg::ST_IDLE;
      cnt_q   <= '0;
      k_q     <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      k_q     <= k_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    idx_q    <= idx_d;
    val_q    <= val_d;
    carry_q  <= carry_d;
    sts_q    <= sts_d;
    res_q    <= res_d;
    pos_q    <= pos_d;
    rem_q    <= rem_d;
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    sdone_q  <= sdone_d;
    o_sts_q  <= o_sts_d;
    o_data_q <= o_data_d;
    o_pos_q  <= o_pos_d;
    o_rem_q  <= o_rem_d;
    o_cnt_q  <= o_cnt_d;
    o_emp_q  <= o_emp_d;
  end

  assign out_valid_o     = ov_q;
  assign status_o        = o_sts_q;
  assign data_o          = o_data_q;
  assign position_o      = o_pos_q;
  assign removed_count_o = o_rem_q;
  assign entry_count_o   = o_cnt_q;
  assign is_empty_o      = o_emp_q;

  `OATE_ASSERT_NOW(a_cnt_bound, 1'b1, MW'(cnt_q) <= MW'(DEPTH), "count above depth")
  `OATE_ASSERT_NOW(a_scan_k, state_q == oate_pkg::ST_SCAN, MW'(k_q) < MW'(DEPTH),
                   "scan index past last cell")
  `OATE_ASSERT_NOW(a_settle_op, state_q == oate_pkg::ST_SETTLE,
                   op_q == oate_pkg::ACT_REMOVE, "compaction outside remove all")
  `OATE_ASSERT_NEXT(a_accept_busy, in_valid_i && !in_stall_o,
                    state_q != oate_pkg::ST_IDLE, "accepted beat left sequencer idle")

endmodule

// File: hw/rtl/oate_cell.sv
// One storage cell of the entry chain
module oate_cell (
  input  logic                clk_i,
  input  oate_pkg::cell_mode_e mode_i,
  input  oate_pkg::cell_t     up_i,
  input  oate_pkg::cell_t     dn_i,
  output oate_pkg::cell_t     q_o
);

  oate_pkg::cell_t cell_q, cell_d;

  always_comb begin
    cell_d = cell_q;
    unique case (mode_i)
      oate_pkg::CM_SHIFT: begin
        cell_d = up_i;
      end
      oate_pkg::CM_SETTLE: begin
        // hole below a kept entry: the pair swaps, the hole rises
        if (cell_q.hole && !up_i.hole) begin
          cell_d.hole = 1'b0;
          cell_d.data = up_i.data;
        end else if (!cell_q.hole && dn_i.hole) begin
          cell_d.hole = 1'b1;
          cell_d.data = dn_i.data;
        end
      end
      default: begin
        cell_d = cell_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    cell_q <= cell_d;
  end

  assign q_o = cell_q;

endmodule

// File: bench/tb.sv
// Self-checking bench for the ordered array table engine
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Depth = oate_pkg::DepthDef;
  localparam int unsigned NumRandom = 1074;
  localparam longint unsigned CycleLimit = 64'd20_000_000;

  typedef struct packed {
    logic [2:0]         action;
    logic [8:0]         index;
    logic signed [31:0] value;
  } request_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] data;
    logic [7:0]         position;
    logic [8:0]         removed_count;
    logic [8:0]         entry_count;
    logic               is_empty;
  } reply_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [2:0] action_i = '0;
  logic [8:0] index_i = '0;
  logic signed [31:0] value_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [2:0] status_o;
  logic signed [31:0] data_o;
  logic [7:0] position_o;
  logic [8:0] removed_count_o;
  logic [8:0] entry_count_o;
  logic is_empty_o;

  ordered_array_table_engine u_dut (.*);

  always #1 clk_i = ~clk_i;

  request_t pending_q[$];
  reply_t   reply_q[$];
  logic signed [31:0] table_mem[Depth];
  int unsigned table_count = 0;
  int unsigned errors = 0;
  int unsigned replies_seen = 0;
  int unsigned total_items = 0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  longint unsigned cycles = 0;

  function automatic int unsigned gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 200);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 4);
    return 0;
  endfunction

  // Apply one action to the shadow table and produce the expected reply
  function automatic reply_t table_apply(request_t rq);
    reply_t r;
    int unsigned w, lo, hi, mid;
    r = '0;
    r.status = oate_pkg::STS_OK;
    case (oate_pkg::action_e'(rq.action))
      oate_pkg::ACT_PUSH: begin
        if (table_count >= Depth) r.status = oate_pkg::STS_FULL;
        else begin
          table_mem[table_count] = rq.value;
          table_count++;
        end
      end
      oate_pkg::ACT_POP: begin
        if (table_count == 0) r.status = oate_pkg::STS_EMPTY;
        else begin
          table_count--;
          r.data = table_mem[table_count];
        end
      end
      oate_pkg::ACT_INSERT: begin
        if (rq.index > table_count) r.status = oate_pkg::STS_RANGE;
        else if (table_count >= Depth) r.status = oate_pkg::STS_FULL;
        else begin
          for (int i = table_count; i > rq.index; i--) table_mem[i] = table_mem[i-1];
          table_mem[rq.index] = rq.value;
          table_count++;
        end
      end
      oate_pkg::ACT_DELETE: begin
        if (rq.index >= table_count) r.status = oate_pkg::STS_RANGE;
        else begin
          r.data = table_mem[rq.index];
          for (int i = rq.index; i + 1 < table_count; i++) table_mem[i] = table_mem[i+1];
          table_count--;
        end
      end
      oate_pkg::ACT_REMOVE: begin
        w = 0;
        for (int i = 0; i < table_count; i++)
          if (table_mem[i] != rq.value) begin
            table_mem[w] = table_mem[i];
            w++;
          end
        r.removed_count = 9'(table_count - w);
        table_count = w;
      end
      oate_pkg::ACT_FIND: begin
        r.status = oate_pkg::STS_MISS;
        for (int i = 0; i < table_count; i++)
          if (table_mem[i] == rq.value) begin
            r.status = oate_pkg::STS_OK;
            r.position = 8'(i);
            break;
          end
      end
      oate_pkg::ACT_SEARCH: begin
        lo = 0;
        hi = table_count;
        r.status = oate_pkg::STS_MISS;
        while (lo < hi) begin
          mid = lo + (hi - lo) / 2;
          if (table_mem[mid] == rq.value) begin
            r.status = oate_pkg::STS_OK;
            r.position = 8'(mid);
            break;
          end else if (table_mem[mid] < rq.value) lo = mid + 1;
          else hi = mid;
        end
      end
      default: begin
        if (rq.index >= table_count) r.status = oate_pkg::STS_RANGE;
        else r.data = table_mem[rq.index];
      end
    endcase
    r.entry_count = 9'(table_count);
    r.is_empty = (table_count == 0);
    return r;
  endfunction

  // Driver: valid is decided from the gap counter and the pending queue, never from stall
  always @(posedge clk_i) begin
    int unsigned g;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        reply_q.push_back(table_apply(request_t'({action_i, index_i, value_i})));
        g = gap_len();
        if (g == 0 && pending_q.size() > 0) begin
          {action_i, index_i, value_i} <= pending_q.pop_front();
        end else begin
          in_valid_i <= 1'b0;
          gap_left <= g;
        end
      end else if (!in_valid_i) begin
        if (gap_left > 0) gap_left <= gap_left - 1;
        else if (pending_q.size() > 0) begin
          {action_i, index_i, value_i} <= pending_q.pop_front();
          in_valid_i <= 1'b1;
        end
      end
    end
  end

  // Monitor with random output stall
  always @(posedge clk_i) begin
    reply_t exp_r;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        replies_seen++;
        if (reply_q.size() == 0) begin
          $error("reply beat with nothing expected");
          errors++;
        end else begin
          exp_r = reply_q.pop_front();
          if (status_o !== exp_r.status) begin
            $error("status exp %0d got %0d", exp_r.status, status_o); errors++;
          end
          if (data_o !== exp_r.data) begin
            $error("data exp %0d got %0d", exp_r.data, data_o); errors++;
          end
          if (position_o !== exp_r.position) begin
            $error("position exp %0d got %0d", exp_r.position, position_o); errors++;
          end
          if (removed_count_o !== exp_r.removed_count) begin
            $error("removed_count exp %0d got %0d", exp_r.removed_count, removed_count_o);
            errors++;
          end
          if (entry_count_o !== exp_r.entry_count) begin
            $error("entry_count exp %0d got %0d", exp_r.entry_count, entry_count_o);
            errors++;
          end
          if (is_empty_o !== exp_r.is_empty) begin
            $error("is_empty exp %0d got %0d", exp_r.is_empty, is_empty_o); errors++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall_i <= 1'b1;
      end else begin
        stall_left <= gap_len();
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic request_t mk(oate_pkg::action_e a, int unsigned ix,
                                  logic signed [31:0] v);
    request_t rq;
    rq.action = a;
    rq.index = 9'(ix);
    rq.value = v;
    return rq;
  endfunction

  task automatic queue_item(request_t rq);
    pending_q.push_back(rq);
    total_items++;
  endtask

  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 7) - 4;  // small pool so matches happen
      1: return {$urandom_range(0, 1) ? 1'b1 : 1'b0, 31'(0)} | 32'($urandom_range(0, 1));
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int unsigned ix;
    oate_pkg::action_e a;
    logic signed [31:0] v;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty table errors, extremes, full table, sorted search
    queue_item(mk(oate_pkg::ACT_POP, 0, 0));
    queue_item(mk(oate_pkg::ACT_READ, 0, 0));
    queue_item(mk(oate_pkg::ACT_DELETE, 0, 0));
    queue_item(mk(oate_pkg::ACT_FIND, 0, 5));
    queue_item(mk(oate_pkg::ACT_SEARCH, 0, 5));
    queue_item(mk(oate_pkg::ACT_REMOVE, 0, 5));
    queue_item(mk(oate_pkg::ACT_INSERT, 1, 9));
    queue_item(mk(oate_pkg::ACT_INSERT, 0, 32'sh8000_0000));
    queue_item(mk(oate_pkg::ACT_PUSH, 0, 32'sh7fff_ffff));
    queue_item(mk(oate_pkg::ACT_INSERT, 1, 0));
    queue_item(mk(oate_pkg::ACT_SEARCH, 0, 32'sh7fff_ffff));
    queue_item(mk(oate_pkg::ACT_SEARCH, 0, 1));
    queue_item(mk(oate_pkg::ACT_FIND, 0, 0));
    queue_item(mk(oate_pkg::ACT_READ, 511, 0));
    queue_item(mk(oate_pkg::ACT_DELETE, 1, 0));
    queue_item(mk(oate_pkg::ACT_READ, 1, 0));
    for (int i = 0; i < Depth; i++) queue_item(mk(oate_pkg::ACT_PUSH, 0, 7));
    queue_item(mk(oate_pkg::ACT_INSERT, 0, 1));
    queue_item(mk(oate_pkg::ACT_INSERT, 300, 1));
    queue_item(mk(oate_pkg::ACT_READ, 255, 0));
    queue_item(mk(oate_pkg::ACT_REMOVE, 0, 7));

    // Random: all eight actions, biased towards pushes and inserts to grow the table
    for (int n = 0; n < NumRandom; n++) begin
      a = oate_pkg::action_e'($urandom_range(0, 7));
      if ($urandom_range(0, 3) == 0) begin
        a = ($urandom_range(0, 1)) ? oate_pkg::ACT_PUSH : oate_pkg::ACT_INSERT;
      end
      ix = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 511) : $urandom_range(0, 40);
      v = rand_value();
      queue_item(mk(a, ix, v));
    end

    wait (replies_seen >= total_items);
    repeat (1000) @(posedge clk_i);
    $display("Checked %0d results across all eight actions, with full, empty,",
             replies_seen);
    $display("out-of-range and miss cases and random receiver stalls");
    if (errors == 0 && reply_q.size() == 0 && replies_seen == total_items)
      $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule
